// ===== src/alara_pkg.sv =====
// ----------------------------------------------------------------------------
// alara_pkg: shared types and codes for the append / remove-all list
// Payload structs for both channels, operation and status codes, the control
// bundle that the top level drives into every list cell, and default sizes.
// ----------------------------------------------------------------------------
package alara_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes.
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entries_now;
    logic [COUNT_W-1:0]  removed_count;
  } out_item_t;

  // Control bundle broadcast to every cell of the chain.
  typedef struct packed {
    logic append_en;  // write the key into the cell at the fill position
    logic mark;       // compare phase: flag matches and unused cells as holes
    logic sweep;      // compaction round in progress
    logic odd_round;  // pairing of the current round
  } cell_ctrl_t;

endpackage

// ===== src/alara_cell.sv =====
// ----------------------------------------------------------------------------
// alara_cell: one entry of the list chain
// Holds one stored word, a hole flag and a tally bit. During compaction it
// pairs with a neighbor and moves live words toward the head of the chain.
// ----------------------------------------------------------------------------
module alara_cell #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0,
  parameter int CNT_W      = 5
) (
  input  logic                    clk,
  input  alara_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]   key,
  input  logic [CNT_W-1:0]        fill,
  input  logic [DATA_WIDTH-1:0]   right_data,
  input  logic                    right_hole,
  input  logic                    right_tally,
  input  logic                    left_hole,
  output logic [DATA_WIDTH-1:0]   data_out,
  output logic                    hole_out,
  output logic                    tally_out
);
  import alara_pkg::*;

  localparam logic HAS_RIGHT = (INDEX < CAPACITY - 1);
  localparam logic HAS_LEFT  = (INDEX > 0);
  localparam logic IDX_ODD   = ((INDEX % 2) == 1);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hole_r, hole_nxt;
  logic                  tally_r, tally_nxt;
  logic                  live, match, is_left;

  always_comb begin
    live    = (fill > CNT_W'(INDEX));
    match   = (data_r == key);
    // In even rounds even cells lead a pair, in odd rounds odd cells do.
    is_left = (IDX_ODD == ctrl.odd_round);

    data_nxt  = data_r;
    hole_nxt  = hole_r;
    tally_nxt = tally_r;

    if (ctrl.append_en && (fill == CNT_W'(INDEX))) begin
      data_nxt = key;
    end

    if (ctrl.mark) begin
      hole_nxt  = !live || match;
      tally_nxt = live && match;
    end else if (ctrl.sweep) begin
      tally_nxt = right_tally;
      if (is_left) begin
        if (HAS_RIGHT && hole_r && !right_hole) begin
          data_nxt = right_data;
          hole_nxt = 1'b0;
        end
      end else begin
        if (HAS_LEFT && left_hole && !hole_r) begin
          hole_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    hole_r  <= hole_nxt;
    tally_r <= tally_nxt;
  end

  assign data_out  = data_r;
  assign hole_out  = hole_r;
  assign tally_out = tally_r;

endmodule

// ===== src/array_list_append_remove_all_top.sv =====
// ----------------------------------------------------------------------------
// array_list_append_remove_all_top: ordered list with append and remove-all
// Up to CAPACITY words kept in a chain of cells; removes compact in place.
// ----------------------------------------------------------------------------
// An append, a full reject or an empty remove loads its result into the
// output register as it is taken; a remove with a non-empty list runs a
// compare step, CAPACITY odd-even compaction rounds and a finish step that
// waits for a free output register. One item at a time: no new transfer is
// taken until the result of the last one has been registered.
// Reset (rst_n low, synchronous) empties the list and clears the handshake.
module array_list_append_remove_all_top #(
  parameter int CAPACITY   = alara_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = alara_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alara_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alara_pkg::out_item_t out_data
);
  import alara_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RND_W = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MARK  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      rm_cnt_r, rm_cnt_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  load_out;
  logic [DATA_WIDTH-1:0] in_key;
  logic [DATA_WIDTH-1:0] cell_key;
  logic signed [63:0]    value_ext;
  logic [CNT_W+4:0]      fill_wide, rm_wide;
  logic [CNT_W-1:0]      fill_after;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
  logic                  hole_w  [CAPACITY];
  logic                  tally_w [CAPACITY];

  // The output register frees up in the same cycle its result is taken.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // The 32-bit value is sign-extended and then cut to the stored word width.
  assign value_ext = 64'(in_data.value);
  assign in_key    = value_ext[DATA_WIDTH-1:0];

  // Appends write straight from the input; the compare phase uses the key register.
  assign cell_key = (state_r == S_IDLE) ? in_key : key_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rm_cnt_nxt    = rm_cnt_r;
    rnd_nxt       = rnd_r;
    key_nxt       = key_r;
    out_data_nxt  = out_data_r;
    load_out      = 1'b0;
    fill_after    = fill_r;
    ctrl          = '0;
    ctrl.odd_round = rnd_r[0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt    = in_key;
          rm_cnt_nxt = '0;
          if (in_data.func == FUNC_APPEND) begin
            load_out = 1'b1;
            if (fill_r >= CNT_W'(CAPACITY)) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              ctrl.append_en = 1'b1;
              fill_after     = fill_r + CNT_W'(1);
              out_data_nxt.status = ST_APPENDED;
            end
          end else if (fill_r == '0) begin
            load_out = 1'b1;
            out_data_nxt.status = ST_EMPTY;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        // Every cell compares its word against the key in parallel.
        ctrl.mark = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        // One odd-even round per cycle; the tally bits drain out of cell 0.
        ctrl.sweep = 1'b1;
        rm_cnt_nxt = rm_cnt_r + CNT_W'(tally_w[0]);
        if (rnd_r == RND_W'(CAPACITY - 1)) begin
          state_nxt = S_DONE;
        end else begin
          rnd_nxt = rnd_r + RND_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          fill_after = fill_r - rm_cnt_r;
          out_data_nxt.status = (rm_cnt_r != '0) ? ST_REMOVED : ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Counts are reported modulo 32, as the result fields are five bits wide.
    fill_wide = {5'b0, fill_after};
    rm_wide   = {5'b0, rm_cnt_nxt};
    if (load_out) begin
      fill_nxt                   = fill_after;
      out_data_nxt.entries_now   = fill_wide[COUNT_W-1:0];
      out_data_nxt.removed_count = rm_wide[COUNT_W-1:0];
    end

    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rm_cnt_r    <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rm_cnt_r    <= rm_cnt_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The chain: cell i holds list entry i. Each cell sees its right neighbor's
  // word, hole flag and tally bit, and its left neighbor's hole flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_hole;
    logic                  r_tally;
    logic                  l_hole;

    if (i < CAPACITY - 1) begin : g_right
      assign r_data  = data_w[i+1];
      assign r_hole  = hole_w[i+1];
      assign r_tally = tally_w[i+1];
    end else begin : g_tail
      assign r_data  = '0;
      assign r_hole  = 1'b1;
      assign r_tally = 1'b0;
    end

    if (i > 0) begin : g_left
      assign l_hole = hole_w[i-1];
    end else begin : g_head
      assign l_hole = 1'b0;
    end

    alara_cell #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key        (cell_key),
      .fill       (fill_r),
      .right_data (r_data),
      .right_hole (r_hole),
      .right_tally(r_tally),
      .left_hole  (l_hole),
      .data_out   (data_w[i]),
      .hole_out   (hole_w[i]),
      .tally_out  (tally_w[i])
    );
  end

  // The fill count never passes the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // A finished remove never deletes more entries than were stored.
  a_rm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (rm_cnt_r <= fill_r))
    else $error("removed count above fill count");

  // An accepted append into a list with room grows the list by one.
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.func == FUNC_APPEND) && (fill_r < CNT_W'(CAPACITY)))
      |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("append did not grow the list");

  // The last compaction round always leads to the finish state.
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SWEEP) && (rnd_r == RND_W'(CAPACITY - 1))) |=> (state_r == S_DONE))
    else $error("sweep did not end after the last round");

endmodule
